// ===== design/mono_framebuffer_rasterizer_defines.svh =====
// Assertion macros for the frame rasterizer.
`ifndef MONO_FRAMEBUFFER_RASTERIZER_DEFINES_SVH
`define MONO_FRAMEBUFFER_RASTERIZER_DEFINES_SVH
`define MFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define MFR_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== design/mfr_pkg.sv =====
package mfr_pkg;
  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 64;
  localparam logic [2:0] CmdClear  = 3'd0;
  localparam logic [2:0] CmdPoint  = 3'd1;
  localparam logic [2:0] CmdLine   = 3'd2;
  localparam logic [2:0] CmdRect   = 3'd3;
  localparam logic [2:0] CmdCircle = 3'd4;
  localparam logic [2:0] CmdFcirc  = 3'd5;
  localparam logic [2:0] CmdRead   = 3'd6;
  // Pixel write request from the shape sequencer.
  typedef struct packed {
    logic              valid;
    logic              toggle;
    logic signed [9:0] x;
    logic signed [9:0] y;
  } pix_req_t;
endpackage

// ===== design/mfr_pixel_unit.sv =====
// Read-modify-write of one pixel at a time over a synchronous frame store.
module mfr_pixel_unit #(
  parameter int unsigned SCREEN_WIDTH  = mfr_pkg::ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = mfr_pkg::ScreenHeight,
  localparam int unsigned Pages = (SCREEN_HEIGHT + 7) / 8,
  localparam int unsigned Depth = Pages * SCREEN_WIDTH,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfr_pkg::pix_req_t req_i,
  input  logic              clr_we_i,
  input  logic [AW-1:0]     clr_addr_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [7:0]        rd_data_o,
  output logic              busy_o,
  output logic              clip_o
);
  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;
  logic       pend_q;
  logic [AW-1:0] addr_q;
  logic [7:0] mask_q;
  logic       tog_q;
  logic       onscr;
  logic [AW-1:0] addr;
  logic [7:0] wdata;

  assign onscr = !req_i.x[9] && !req_i.y[9] &&
                 (req_i.x < $signed(10'(SCREEN_WIDTH))) &&
                 (req_i.y < $signed(10'(SCREEN_HEIGHT)));
  assign addr = AW'(req_i.y[9:3]) * AW'(SCREEN_WIDTH) + AW'(req_i.x);
  assign clip_o = req_i.valid && !onscr;
  assign busy_o = pend_q;
  assign rd_data_o = rdata_q;
  assign wdata = tog_q ? (rdata_q ^ mask_q) : (rdata_q | mask_q);

  always_ff @(posedge clk_i) begin
    if (clr_we_i) begin
      mem[clr_addr_i] <= 8'h00;
    end else if (pend_q) begin
      mem[addr_q] <= wdata;
    end
    if (req_i.valid && onscr) begin
      rdata_q <= mem[addr];
    end else if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= req_i.valid && onscr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      addr_q <= addr;
      mask_q <= 8'(1) << req_i.y[2:0];
      tog_q  <= req_i.toggle;
    end
  end
endmodule

// ===== design/mono_framebuffer_rasterizer.sv =====
// One transaction at a time; the next is taken in the cycle the result shows. Each pixel
// needs a read and then a write of the frame store; clipped pixels are not written.
// Reset: a clearing pass zeroes all 1024 bytes of the store with busy high; no receiver stall.
// A clear command runs the same clearing pass.
module mono_framebuffer_rasterizer #(
  parameter int unsigned SCREEN_WIDTH  = mfr_pkg::ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = mfr_pkg::ScreenHeight
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command_i,
  input  logic [6:0] x_start_i,
  input  logic [5:0] y_start_i,
  input  logic [6:0] x_end_i,
  input  logic [5:0] y_end_i,
  input  logic [7:0] rect_width_i,
  input  logic [6:0] rect_height_i,
  input  logic [5:0] radius_i,
  input  logic       xor_mode_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       clipped_o
);
  localparam int unsigned Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned Depth = Pages * SCREEN_WIDTH;
  localparam int unsigned AW = $clog2(Depth);

  typedef enum logic [8:0] {
    StClr  = 9'b000000001,
    StIdle = 9'b000000010,
    StLine = 9'b000000100,
    StRect = 9'b000001000,
    StCirc = 9'b000010000,
    StSpan = 9'b000100000,
    StRd   = 9'b001000000,
    StDone = 9'b010000000,
    StWait = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [AW:0] clr_q;
  logic [2:0]  cmd_q;
  logic        tog_q, clip_q, is_rd_q, rd_ok_q;
  logic signed [9:0] x_q, y_q, cx_q, cy_q, sx_q, sy_q;
  logic signed [9:0] dx_q, dy_q, dist_q, ex_q, ey_q, i_q;
  logic signed [9:0] a_q, b_q, f_q, ddx_q, ddy_q;
  logic signed [9:0] w_q, h_q, j_q;
  logic [3:0]  k_q;      // point slot within one circle step
  logic        post_q;   // drawing the final points after the loop
  logic signed [9:0] sp_x_q, sp_y_q, sp_len_q, sp_i_q;
  logic [5:0]  radius_q;
  logic signed [9:0] r_s;
  mfr_pkg::pix_req_t req;
  logic pu_busy, pu_clip;
  logic [7:0] pu_data;
  logic clr_we, rd_en;
  logic [AW-1:0] rd_addr;

  mfr_pixel_unit #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_pix (
    .clk_i, .rst_ni, .req_i(req), .clr_we_i(clr_we), .clr_addr_i(clr_q[AW-1:0]),
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(pu_data), .busy_o(pu_busy),
    .clip_o(pu_clip)
  );

  assign busy = (state_q != StIdle);
  assign clr_we = (state_q == StClr);
  assign rd_en = (state_q == StRd);
  assign rd_addr = AW'(y_q[9:3]) * AW'(SCREEN_WIDTH) + AW'(x_q);
  assign r_s = 10'(radius_q);

  // Circle: point offsets for the current slot; the end points use the radius.
  logic signed [9:0] px, py;
  always_comb begin
    px = cx_q; py = cy_q;
    if (post_q) begin
      case (k_q[1:0])
        2'd0: begin px = cx_q; py = cy_q + r_s; end
        2'd1: begin px = cx_q; py = cy_q - r_s; end
        2'd2: begin px = cx_q + r_s; py = cy_q; end
        default: begin px = cx_q - r_s; py = cy_q; end
      endcase
    end else begin
      case (k_q[2:0])
        3'd0: begin px = cx_q + a_q; py = cy_q + b_q; end
        3'd1: begin px = cx_q + b_q; py = cy_q + a_q; end
        3'd2: begin px = cx_q + a_q; py = cy_q - b_q; end
        3'd3: begin px = cx_q + b_q; py = cy_q - a_q; end
        3'd4: begin px = cx_q - b_q; py = cy_q + a_q; end
        3'd5: begin px = cx_q - a_q; py = cy_q + b_q; end
        3'd6: begin px = cx_q - b_q; py = cy_q - a_q; end
        default: begin px = cx_q - a_q; py = cy_q - b_q; end
      endcase
    end
  end

  // Filled circle: span origin for the current slot.
  logic signed [9:0] fx, fy, fl;
  always_comb begin
    fx = cx_q; fy = cy_q - b_q; fl = 10'sd2 * b_q + 10'sd1;
    if (!post_q) begin
      case (k_q[1:0])
        2'd0: begin fx = cx_q + a_q; fy = cy_q - b_q; fl = 10'sd2 * b_q + 10'sd1; end
        2'd1: begin fx = cx_q + b_q; fy = cy_q - a_q; fl = 10'sd2 * a_q + 10'sd1; end
        2'd2: begin fx = cx_q - a_q; fy = cy_q - b_q; fl = 10'sd2 * b_q + 10'sd1; end
        default: begin fx = cx_q - b_q; fy = cy_q - a_q; fl = 10'sd2 * a_q + 10'sd1; end
      endcase
    end
  end

  // Midpoint step shared by both circle forms.
  logic signed [9:0] na, nb, nf, nddx, nddy;
  always_comb begin
    nb = b_q; nddy = ddy_q; nf = f_q;
    if (f_q >= 0) begin
      nb = b_q - 10'sd1; nddy = ddy_q + 10'sd2; nf = f_q + ddy_q + 10'sd2;
    end
    na = a_q + 10'sd1; nddx = ddx_q + 10'sd2; nf = nf + nddx;
  end

  logic go;
  assign go = !pu_busy;

  always_comb begin
    req = '0;
    req.toggle = tog_q;
    case (state_q)
      StLine: begin req.valid = go; req.x = x_q; req.y = y_q; end
      StRect: begin
        req.valid = go && (w_q > 0) && (h_q > 0);
        req.x = x_q + i_q; req.y = y_q + j_q;
      end
      StCirc: begin req.valid = go && (k_q != 4'hf); req.x = px; req.y = py; end
      StSpan: begin
        req.valid = go && (sp_i_q < sp_len_q);
        req.x = sp_x_q; req.y = sp_y_q + sp_i_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q   <= '0;
      clip_q  <= 1'b0;
      is_rd_q <= 1'b0;
      done_o  <= 1'b0;
      read_data_o <= '0;
      clipped_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req.valid && pu_clip) clip_q <= 1'b1;
      case (state_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(Depth - 1)) state_q <= is_rd_q ? StDone : StIdle;
        end
        StIdle: begin
          if (start) begin
            clip_q <= 1'b0; rd_ok_q <= 1'b0;
            is_rd_q <= (command_i == mfr_pkg::CmdClear);
            // Only point and rectangle may toggle.
            tog_q <= (command_i inside {mfr_pkg::CmdPoint, mfr_pkg::CmdRect}) ?
                     xor_mode_i : 1'b0;
            x_q <= 10'(x_start_i); y_q <= 10'(y_start_i);
            cx_q <= 10'(x_start_i); cy_q <= 10'(y_start_i);
            i_q <= '0; j_q <= '0; post_q <= (radius_i == 6'd0);
            k_q <= (command_i inside {mfr_pkg::CmdCircle, mfr_pkg::CmdFcirc}) ?
                   4'hf : 4'h0;
            w_q <= 10'(rect_width_i); h_q <= 10'(rect_height_i);
            a_q <= '0; b_q <= 10'(radius_i); f_q <= 10'sd1 - 10'(radius_i);
            ddx_q <= 10'sd1; ddy_q <= -(10'(radius_i) <<< 1);
            ex_q <= '0; ey_q <= '0;
            begin
              logic signed [9:0] ddx, ddy;
              ddx = 10'(x_end_i) - 10'(x_start_i);
              ddy = 10'(y_end_i) - 10'(y_start_i);
              sx_q <= ddx < 0 ? -10'sd1 : 10'sd1;
              sy_q <= ddy < 0 ? -10'sd1 : 10'sd1;
              if (ddx < 0) ddx = -ddx;
              if (ddy < 0) ddy = -ddy;
              dx_q <= ddx; dy_q <= ddy;
              // A point is a line of one pixel.
              dist_q <= (command_i == mfr_pkg::CmdPoint) ? 10'sd0 :
                        (ddx > ddy ? ddx : ddy);
            end
            case (command_i)
              mfr_pkg::CmdClear:  begin clr_q <= '0; state_q <= StClr; end
              mfr_pkg::CmdPoint:  state_q <= StLine;
              mfr_pkg::CmdLine:   state_q <= StLine;
              mfr_pkg::CmdRect:   state_q <= StRect;
              mfr_pkg::CmdCircle: state_q <= StCirc;
              mfr_pkg::CmdFcirc:  begin state_q <= StSpan; sp_len_q <= '0; sp_i_q <= '0; end
              mfr_pkg::CmdRead:   state_q <= StRd;
              default:            state_q <= StDone;
            endcase
            cmd_q <= command_i;
          end
        end
        StLine: if (go) begin
          if (i_q == dist_q) state_q <= StWait;
          else begin
            logic signed [9:0] nex, ney;
            nex = ex_q + dx_q; ney = ey_q + dy_q;
            if (nex >= dist_q) begin nex = nex - dist_q; x_q <= x_q + sx_q; end
            if (ney >= dist_q) begin ney = ney - dist_q; y_q <= y_q + sy_q; end
            ex_q <= nex; ey_q <= ney; i_q <= i_q + 10'sd1;
          end
        end
        StRect: if (go) begin
          if (w_q <= 0 || h_q <= 0) state_q <= StWait;
          else if (j_q == h_q - 10'sd1) begin
            j_q <= '0;
            if (i_q == w_q - 10'sd1) state_q <= StWait;
            else i_q <= i_q + 10'sd1;
          end else j_q <= j_q + 10'sd1;
        end
        StCirc: if (go) begin
          // Slot 15 marks "advance the midpoint step".
          if (k_q == 4'hf) begin
            if (post_q) k_q <= '0;
            else if (a_q < b_q) begin
              a_q <= na; b_q <= nb; f_q <= nf; ddx_q <= nddx; ddy_q <= nddy; k_q <= '0;
            end else begin post_q <= 1'b1; k_q <= '0; end
          end else if (post_q && k_q == 4'd3) state_q <= StWait;
          else if (!post_q && k_q == 4'd7) k_q <= 4'hf;
          else k_q <= k_q + 4'd1;
        end
        StSpan: if (go) begin
          if (sp_i_q < sp_len_q) sp_i_q <= sp_i_q + 10'sd1;
          else if (k_q == 4'hf) begin
            if (post_q) begin k_q <= 4'd0; end
            else if (a_q < b_q) begin
              a_q <= na; b_q <= nb; f_q <= nf; ddx_q <= nddx; ddy_q <= nddy; k_q <= 4'd0;
            end else begin post_q <= 1'b1; k_q <= 4'd0; end
            sp_len_q <= '0;
          end else if (k_q[3]) begin
            if (post_q) state_q <= StWait; else k_q <= 4'hf;
            sp_len_q <= '0;
          end else begin
            // Load the span for this slot; the center span is r-based.
            sp_x_q <= post_q ? cx_q : fx;
            sp_y_q <= post_q ? cy_q - 10'(radius_q) : fy;
            sp_len_q <= post_q ? (10'(radius_q) <<< 1) + 10'sd1 : fl;
            sp_i_q <= '0;
            k_q <= (post_q || k_q == 4'd3) ? 4'd8 : k_q + 4'd1;
          end
        end
        StRd: begin
          rd_ok_q <= (x_q < 10'(SCREEN_WIDTH)) && (y_q[9:3] < 7'(Pages));
          state_q <= StDone; is_rd_q <= 1'b1;
          if (!((x_q < 10'(SCREEN_WIDTH)) && (y_q[9:3] < 7'(Pages)))) clip_q <= 1'b1;
        end
        StWait: if (go) state_q <= StDone;
        StDone: begin
          done_o <= 1'b1;
          read_data_o <= (cmd_q == mfr_pkg::CmdRead && rd_ok_q) ? pu_data : 8'h00;
          clipped_o <= clip_q;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) radius_q <= radius_i;
  end
endmodule

// ===== design/mfr_checker.sv =====
`include "mono_framebuffer_rasterizer_defines.svh"
module mfr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic [7:0] read_data_o
);
  `MFR_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> $past(busy))
  `MFR_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `MFR_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy)
  `MFR_ASSERT(a_data_known, clk_i, rst_ni, done_o |-> !$isunknown(read_data_o))
  `MFR_ASSERT_NR(a_rst_busy, clk_i, !rst_ni |=> busy)
endmodule

bind mono_framebuffer_rasterizer mfr_checker u_mfr_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .read_data_o
);
